// File: design/vibration_settle_detector_assert.svh
// Assertion macros used by the settle detector checker.
`ifndef VIBRATION_SETTLE_DETECTOR_ASSERT_SVH
`define VIBRATION_SETTLE_DETECTOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define VSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vibration_settle_detector check failed");

// Check a property on every clock edge, reset included.
`define VSD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("vibration_settle_detector check failed");

`endif

// File: design/vsd_pkg.sv
// Shared types, register indexes and helpers of the vibration settle detector.
`timescale 1ns / 1ps
package vsd_pkg;

  localparam int unsigned AccelW   = 13;
  localparam int unsigned StepsW   = 24;
  localparam int unsigned ThreshW  = 26;
  localparam int unsigned MsW      = 16;
  localparam int unsigned GravW    = 9;
  localparam int unsigned DwellW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 26;

  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_TICK     = 2'd1,
    KIND_START    = 2'd2,
    KIND_DEASSERT = 2'd3
  } kind_e;

  localparam logic [CfgIdxW-1:0] CFG_SENSOR_PRESENT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUIET_THRESH_SQ = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_QUIET_WINDOW_MS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY_LSB     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DWELL_BASE_MS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DWELL_PER_STEP  = 3'd5;

  typedef struct packed {
    logic               sensor_present;
    logic [ThreshW-1:0] quiet_threshold_sq;
    logic [MsW-1:0]     quiet_window_ms;
    logic [GravW-1:0]   gravity_lsb;
    logic [MsW-1:0]     dwell_base_ms;
    logic [MsW-1:0]     dwell_per_step_q8;
  } cfg_t;

  // Word handed from the magnitude stage to the state update stage.
  typedef struct packed {
    kind_e             kind;
    logic              quiet;
    logic [DwellW-1:0] step_dwell;
  } prep_t;

  function automatic logic [AccelW-1:0] abs14(input logic signed [AccelW:0] v);
    logic signed [AccelW:0] n;
    n = -v;
    return v[AccelW] ? n[AccelW-1:0] : v[AccelW-1:0];
  endfunction

endpackage

// File: design/vibration_settle_detector.sv
// Top level of the vibration settle detector: config registers and pipeline.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_ready_o   | kind, accel_x/y/z, move_steps
//  out     | output    | out_valid_o / out_ready_i | settled, active
//  cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One word per cycle while the output is not stalled; a taken word passes
// through the input register, the magnitude and product stage, and the state
// update into the result register. The state loop closes in the update stage alone.
// Reset clears all state, the pipeline and the registers to their defaults.
// A stalled output holds its word; words back up stage by stage.
`timescale 1ns / 1ps
module vibration_settle_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic signed [vsd_pkg::AccelW-1:0]   accel_x_i,
  input  logic signed [vsd_pkg::AccelW-1:0]   accel_y_i,
  input  logic signed [vsd_pkg::AccelW-1:0]   accel_z_i,
  input  logic [vsd_pkg::StepsW-1:0]          move_steps_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                settled_o,
  output logic                                active_o,
  input  logic                                cfg_we_i,
  input  logic [vsd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [vsd_pkg::CfgDataW-1:0]        cfg_wdata_i
);
  import vsd_pkg::*;

  cfg_t  cfg_q;
  logic  prep_valid;
  logic  prep_ready;
  prep_t prep_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_present     <= 1'b0;
      cfg_q.quiet_threshold_sq <= ThreshW'(164);
      cfg_q.quiet_window_ms    <= MsW'(50);
      cfg_q.gravity_lsb        <= GravW'(256);
      cfg_q.dwell_base_ms      <= MsW'(100);
      cfg_q.dwell_per_step_q8  <= MsW'(26);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSOR_PRESENT:  cfg_q.sensor_present     <= cfg_wdata_i[0];
        CFG_QUIET_THRESH_SQ: cfg_q.quiet_threshold_sq <= cfg_wdata_i[ThreshW-1:0];
        CFG_QUIET_WINDOW_MS: cfg_q.quiet_window_ms    <= cfg_wdata_i[MsW-1:0];
        CFG_GRAVITY_LSB:     cfg_q.gravity_lsb        <= cfg_wdata_i[GravW-1:0];
        CFG_DWELL_BASE_MS:   cfg_q.dwell_base_ms      <= cfg_wdata_i[MsW-1:0];
        CFG_DWELL_PER_STEP:  cfg_q.dwell_per_step_q8  <= cfg_wdata_i[MsW-1:0];
        default: begin
        end
      endcase
    end
  end

  vsd_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .move_steps_i (move_steps_i),
    .cfg_i        (cfg_q),
    .prep_valid_o (prep_valid),
    .prep_ready_i (prep_ready),
    .prep_o       (prep_word)
  );

  vsd_update u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prep_valid_i (prep_valid),
    .prep_ready_o (prep_ready),
    .prep_i       (prep_word),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .settled_o    (settled_o),
    .active_o     (active_o)
  );

endmodule

// File: design/vsd_prep.sv
// Input register and magnitude / dwell product stage.
`timescale 1ns / 1ps
module vsd_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic signed [vsd_pkg::AccelW-1:0]   accel_x_i,
  input  logic signed [vsd_pkg::AccelW-1:0]   accel_y_i,
  input  logic signed [vsd_pkg::AccelW-1:0]   accel_z_i,
  input  logic [vsd_pkg::StepsW-1:0]          move_steps_i,
  input  vsd_pkg::cfg_t                       cfg_i,
  output logic                                prep_valid_o,
  input  logic                                prep_ready_i,
  output vsd_pkg::prep_t                      prep_o
);
  import vsd_pkg::*;

  logic                     a_valid_q;
  kind_e                    a_kind_q;
  logic signed [AccelW-1:0] a_x_q, a_y_q, a_z_q;
  logic [StepsW-1:0]        a_steps_q;
  logic                     a_adv;

  logic                     b_valid_q;
  prep_t                    b_word_q;
  prep_t                    b_word_d;

  logic signed [AccelW:0]   z_off;
  logic [AccelW-1:0]        ax, ay, az;
  logic [2*AccelW-1:0]      sx, sy, sz;
  logic [2*AccelW:0]        sum_sq;
  logic [StepsW+MsW-1:0]    prod;

  assign a_adv      = a_valid_q && (!b_valid_q || prep_ready_i);
  assign in_ready_o = !a_valid_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_kind_q  <= kind_e'(kind_i);
      a_x_q     <= accel_x_i;
      a_y_q     <= accel_y_i;
      a_z_q     <= accel_z_i;
      a_steps_q <= move_steps_i;
    end
  end

  // Remove one g from Z, then square each axis.
  assign z_off  = {a_z_q[AccelW-1], a_z_q} - $signed({5'd0, cfg_i.gravity_lsb});
  assign ax     = abs14({a_x_q[AccelW-1], a_x_q});
  assign ay     = abs14({a_y_q[AccelW-1], a_y_q});
  assign az     = abs14(z_off);
  assign sx     = ax * ax;
  assign sy     = ay * ay;
  assign sz     = az * az;
  assign sum_sq = {1'b0, sx} + {1'b0, sy} + {1'b0, sz};
  assign prod   = a_steps_q * cfg_i.dwell_per_step_q8;

  always_comb begin
    b_word_d.kind       = a_kind_q;
    b_word_d.quiet      = sum_sq < {1'b0, cfg_i.quiet_threshold_sq};
    b_word_d.step_dwell = prod[StepsW+MsW-1:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_valid_q || prep_ready_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_word_q <= b_word_d;
    end
  end

  assign prep_valid_o = b_valid_q;
  assign prep_o       = b_word_q;

endmodule

// File: design/vsd_update.sv
// Monitoring state update and result register.
`timescale 1ns / 1ps
module vsd_update (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           prep_valid_i,
  output logic           prep_ready_o,
  input  vsd_pkg::prep_t prep_i,
  input  vsd_pkg::cfg_t  cfg_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           settled_o,
  output logic           active_o
);
  import vsd_pkg::*;

  logic              mon_q, mon_d;
  logic              set_q, set_d;
  logic              run_q, run_d;
  logic [MsW-1:0]    qel_q, qel_d;
  logic              dact_q, dact_d;
  logic [DwellW-1:0] dtgt_q, dtgt_d;
  logic [DwellW-1:0] del_q, del_d;
  logic              out_valid_q, settled_q, active_q;

  logic              live;
  logic              adv;
  logic [DwellW:0]   tgt_sum;
  logic [DwellW-1:0] del_inc;

  assign prep_ready_o = !out_valid_q || out_ready_i;
  assign adv          = prep_valid_i && prep_ready_o;
  assign live         = mon_q && !set_q;
  assign tgt_sum      = {1'b0, prep_i.step_dwell} + {{(DwellW+1-MsW){1'b0}}, cfg_i.dwell_base_ms};
  assign del_inc      = (&del_q) ? del_q : del_q + 1'b1;

  always_comb begin
    mon_d  = mon_q;
    set_d  = set_q;
    run_d  = run_q;
    qel_d  = qel_q;
    dact_d = dact_q;
    dtgt_d = dtgt_q;
    del_d  = del_q;
    unique case (prep_i.kind)
      KIND_SAMPLE: begin
        if (live && cfg_i.sensor_present) begin
          if (prep_i.quiet) begin
            if (!run_q) begin
              run_d = 1'b1;
              qel_d = '0;
            end else if (qel_q >= cfg_i.quiet_window_ms) begin
              set_d = 1'b1;
            end
          end else begin
            run_d = 1'b0;
            qel_d = '0;
          end
        end
      end
      KIND_TICK: begin
        if (live) begin
          if (cfg_i.sensor_present) begin
            if (run_q && !(&qel_q)) begin
              qel_d = qel_q + 1'b1;
            end
          end else if (dact_q) begin
            del_d = del_inc;
            if (del_inc >= dtgt_q) begin
              set_d  = 1'b1;
              dact_d = 1'b0;
            end
          end
        end
      end
      KIND_START: begin
        set_d = 1'b0;
        mon_d = 1'b1;
        if (cfg_i.sensor_present) begin
          run_d = 1'b0;
          qel_d = '0;
        end else begin
          dtgt_d = tgt_sum[DwellW] ? '1 : tgt_sum[DwellW-1:0];
          del_d  = '0;
          dact_d = 1'b1;
        end
      end
      KIND_DEASSERT: begin
        set_d  = 1'b0;
        mon_d  = 1'b0;
        dact_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_q       <= 1'b0;
      set_q       <= 1'b0;
      run_q       <= 1'b0;
      qel_q       <= '0;
      dact_q      <= 1'b0;
      dtgt_q      <= '0;
      del_q       <= '0;
      out_valid_q <= 1'b0;
      settled_q   <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      if (prep_ready_o) begin
        out_valid_q <= prep_valid_i;
      end
      if (adv) begin
        mon_q     <= mon_d;
        set_q     <= set_d;
        run_q     <= run_d;
        qel_q     <= qel_d;
        dact_q    <= dact_d;
        dtgt_q    <= dtgt_d;
        del_q     <= del_d;
        settled_q <= set_d;
        active_q  <= mon_d && !set_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign settled_o   = settled_q;
  assign active_o    = active_q;

endmodule

// File: design/vsd_checker.sv
// Port-level checks of the vibration settle detector, bound to the top level.
`timescale 1ns / 1ps
`include "vibration_settle_detector_assert.svh"
module vsd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic settled_o,
  input logic active_o
);

  logic       out_stall;
  logic [1:0] out_flags;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_flags = {settled_o, active_o};

  `VSD_ASSERT(a_flags_exclusive, clk_i, rst_ni, out_valid_o |-> !(settled_o && active_o))
  `VSD_ASSERT(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o |-> out_stall)
  `VSD_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> (out_valid_o && $stable(out_flags)))
  `VSD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind vibration_settle_detector vsd_checker u_vsd_checker (.*);
